// File: rtl/fdtb_pkg.sv
// Shared types and constants of the fragment depth test and blend block.
// Used by every module under rtl except fdtb_fifo; depends on nothing else.
package fdtb_pkg;

    // Widths fixed by the item format
    localparam int ADDR_IN_W     = 16;
    localparam int DEPTH_W       = 32;
    localparam int COLOR_W       = 32;
    localparam int SHADE_W       = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 9;

    // Default store size (address bits)
    localparam int ADDRESS_BITS_DEFAULT = 16;

    // Blend mode codes
    localparam logic [1:0] BLEND_NONE  = 2'd0;
    localparam logic [1:0] BLEND_ADD   = 2'd1;
    localparam logic [1:0] BLEND_ALPHA = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTH_SHADE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_FACTOR = 2'd2;

    // Configuration reset values
    localparam logic [1:0] BLEND_MODE_RST   = BLEND_NONE;
    localparam logic       SMOOTH_SHADE_RST = 1'b1;
    localparam logic [8:0] ALPHA_FACTOR_RST = 9'd256;

    // Shade 1.0 in Q2.14
    localparam logic [14:0] SHADE_ONE = 15'd16384;
    localparam logic [7:0]  CHAN_MAX  = 8'hFF;

    // Item kinds
    localparam logic KIND_FRAGMENT = 1'b0;
    localparam logic KIND_CLEAR    = 1'b1;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        logic                clear;    // unconditional write
        logic                plain;    // texel stored unchanged
        logic                smooth;   // apply shade to RGB
        logic [1:0]          mode;     // normalized blend mode
        logic [7:0]          alpha;    // scaled, saturated texel alpha
        logic [14:0]         shade;    // clamped to 0..1.0
        logic [DEPTH_W-1:0]  depth;
        logic [COLOR_W-1:0]  color;
    } work_t;

endpackage

// File: rtl/fdtb_fifo.sv
// Two-entry queue between the front end and the back end.
// Generic payload width; depends on nothing else.
module fdtb_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [0:1];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/fdtb_front.sv
// Front end: configuration registers, input accept and item classification.
// Depends on fdtb_pkg.
module fdtb_front #(
    parameter int ADDRESS_BITS = fdtb_pkg::ADDRESS_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fdtb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fdtb_pkg::CFG_DATA_W-1:0]      cfg_data,
    // item input
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 kind,
    input  logic [fdtb_pkg::ADDR_IN_W-1:0]       address,
    input  logic [fdtb_pkg::DEPTH_W-1:0]         depth,
    input  logic [fdtb_pkg::COLOR_W-1:0]         color,
    input  logic signed [fdtb_pkg::SHADE_W-1:0]  shade,
    // toward the queue
    output logic                                 q_wr_en,
    output logic [ADDRESS_BITS-1:0]              q_addr,
    output fdtb_pkg::work_t                      q_work,
    input  logic                                 q_full
);

    logic [1:0] blend_mode_reg;
    logic       smooth_shade_reg;
    logic [8:0] alpha_factor_reg;

    logic [1:0]  mode_norm;
    logic [16:0] alpha_prod;
    logic [8:0]  alpha_scaled;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign q_wr_en   = push && !q_full;
    assign q_addr    = ADDRESS_BITS'(address);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg   <= fdtb_pkg::BLEND_MODE_RST;
            smooth_shade_reg <= fdtb_pkg::SMOOTH_SHADE_RST;
            alpha_factor_reg <= fdtb_pkg::ALPHA_FACTOR_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fdtb_pkg::CFG_BLEND_MODE:   blend_mode_reg   <= cfg_data[1:0];
                fdtb_pkg::CFG_SMOOTH_SHADE: smooth_shade_reg <= cfg_data[0];
                fdtb_pkg::CFG_ALPHA_FACTOR: alpha_factor_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // undefined mode code falls back to no blending
    always_comb
    begin
        case (blend_mode_reg)
            fdtb_pkg::BLEND_ADD:   mode_norm = fdtb_pkg::BLEND_ADD;
            fdtb_pkg::BLEND_ALPHA: mode_norm = fdtb_pkg::BLEND_ALPHA;
            default:               mode_norm = fdtb_pkg::BLEND_NONE;
        endcase
    end

    // texel alpha scaled by material factor, saturated
    assign alpha_prod   = 17'(color[31:24]) * 17'(alpha_factor_reg);
    assign alpha_scaled = alpha_prod[16:8];

    // classified item
    always_comb
    begin
        q_work        = '0;
        q_work.clear  = (kind == fdtb_pkg::KIND_CLEAR);
        q_work.plain  = (mode_norm == fdtb_pkg::BLEND_NONE) && !smooth_shade_reg;
        q_work.smooth = smooth_shade_reg;
        q_work.mode   = mode_norm;
        q_work.alpha  = alpha_scaled[8] ? fdtb_pkg::CHAN_MAX : alpha_scaled[7:0];
        q_work.depth  = depth;
        q_work.color  = color;
        if (shade < 0)
        begin
            q_work.shade = '0;
        end
        else if (shade > $signed({1'b0, fdtb_pkg::SHADE_ONE}))
        begin
            q_work.shade = fdtb_pkg::SHADE_ONE;
        end
        else
        begin
            q_work.shade = shade[14:0];
        end
    end

endmodule

// File: rtl/fdtb_back.sv
// Back end: depth and color stores, depth test, shade and blend sequencer,
// and the result register. Depends on fdtb_pkg.
module fdtb_back #(
    parameter int ADDRESS_BITS = fdtb_pkg::ADDRESS_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // from the queue
    input  logic                             q_empty,
    input  logic [ADDRESS_BITS-1:0]          q_addr,
    input  fdtb_pkg::work_t                  q_work,
    output logic                             q_rd_en,
    // result side
    input  logic                             pop,
    output logic                             empty,
    output logic                             written,
    output logic [fdtb_pkg::COLOR_W-1:0]     color_out,
    output logic [fdtb_pkg::DEPTH_W-1:0]     depth_out
);

    localparam int MEM_DEPTH = 1 << ADDRESS_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TEST = 3'd1;
    localparam logic [2:0] ST_MIX  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [fdtb_pkg::DEPTH_W-1:0] depth_mem [0:MEM_DEPTH-1];
    logic [fdtb_pkg::COLOR_W-1:0] color_mem [0:MEM_DEPTH-1];

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic [ADDRESS_BITS-1:0]      addr_reg;
    fdtb_pkg::work_t              work_reg;
    logic [fdtb_pkg::DEPTH_W-1:0] rd_depth_reg;
    logic [fdtb_pkg::COLOR_W-1:0] rd_color_reg;
    logic                         pass_reg;
    logic [7:0]                   shd_reg [0:2];
    logic [15:0]                  mix_reg [0:2];
    logic [23:0]                  rgb_reg;
    logic                         out_valid_reg;
    logic                         written_reg;
    logic [fdtb_pkg::COLOR_W-1:0] color_out_reg;
    logic [fdtb_pkg::DEPTH_W-1:0] depth_out_reg;

    logic                         out_free;
    logic                         finish;
    logic                         wr_en;
    logic [fdtb_pkg::COLOR_W-1:0] new_color;

    assign out_free  = !out_valid_reg || pop;
    assign q_rd_en   = (state_reg == ST_IDLE) && !q_empty;
    assign finish    = (state_reg == ST_DONE) && out_free;
    assign wr_en     = finish && pass_reg;
    assign empty     = !out_valid_reg;
    assign written   = written_reg;
    assign color_out = color_out_reg;
    assign depth_out = depth_out_reg;

    // color that goes into the store on a pass
    always_comb
    begin
        if (work_reg.clear || work_reg.plain)
        begin
            new_color = work_reg.color;
        end
        else
        begin
            new_color = {fdtb_pkg::CHAN_MAX, rgb_reg};
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!q_empty) state_next = ST_TEST;
            ST_TEST: state_next = ST_MIX;
            ST_MIX:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // stores: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            depth_mem[addr_reg] <= work_reg.depth;
            color_mem[addr_reg] <= new_color;
        end
        if (q_rd_en)
        begin
            rd_depth_reg <= depth_mem[q_addr];
            rd_color_reg <= color_mem[q_addr];
        end
    end

    // datapath stages, one RGB lane per channel
    always_ff @(posedge clk)
    begin
        logic [22:0] shade_prod;
        logic [8:0]  add_sum;
        logic [16:0] div_sum;
        logic [7:0]  dst;
        logic [7:0]  dst_weight;
        if (q_rd_en)
        begin
            addr_reg <= q_addr;
            work_reg <= q_work;
        end
        // depth test and shading
        if (state_reg == ST_TEST)
        begin
            pass_reg <= work_reg.clear || (work_reg.depth >= rd_depth_reg);
            for (int k = 0; k < 3; k++)
            begin
                shade_prod = 23'(work_reg.color[16 - 8 * k +: 8]) * 23'(work_reg.shade);
                shd_reg[k] <= work_reg.smooth ? shade_prod[21:14]
                                              : work_reg.color[16 - 8 * k +: 8];
            end
        end
        // blend with the destination
        if (state_reg == ST_MIX)
        begin
            dst_weight = fdtb_pkg::CHAN_MAX - work_reg.alpha;
            for (int k = 0; k < 3; k++)
            begin
                dst = rd_color_reg[16 - 8 * k +: 8];
                add_sum = 9'(shd_reg[k]) + 9'(dst);
                case (work_reg.mode)
                    fdtb_pkg::BLEND_ADD:
                        mix_reg[k] <= add_sum[8] ? 16'(fdtb_pkg::CHAN_MAX)
                                                 : 16'(add_sum[7:0]);
                    fdtb_pkg::BLEND_ALPHA:
                        mix_reg[k] <= 16'(work_reg.alpha) * 16'(shd_reg[k])
                                      + 16'(dst_weight) * 16'(dst);
                    default:
                        mix_reg[k] <= 16'(shd_reg[k]);
                endcase
            end
        end
        // exact truncating divide by 255 for values up to 255*255
        if (state_reg == ST_DIV)
        begin
            for (int k = 0; k < 3; k++)
            begin
                div_sum = 17'(mix_reg[k]) + 17'(mix_reg[k][15:8]) + 17'd1;
                rgb_reg[16 - 8 * k +: 8] <= (work_reg.mode == fdtb_pkg::BLEND_ALPHA)
                                            ? div_sum[15:8] : mix_reg[k][7:0];
            end
        end
        // result register
        if (finish)
        begin
            written_reg   <= pass_reg;
            color_out_reg <= pass_reg ? new_color : rd_color_reg;
            depth_out_reg <= pass_reg ? work_reg.depth : rd_depth_reg;
        end
    end

endmodule

// File: rtl/fragment_depth_test_blend.sv
// Top level of the fragment depth test and blend block.
// Depends on fdtb_pkg, fdtb_front, fdtb_fifo and fdtb_back.

// Pixel back end with per-pixel depth and color stores of 2^ADDRESS_BITS
// entries. Clear items write depth and color at the address; fragments pass
// when their depth is greater than or equal to the stored depth, then are
// shaded and blended into the color store. One result comes out per item,
// in order. The front end takes an item whenever its two-entry queue has
// room; the back end works on one item at a time, taking it through store
// read, depth test and shade multiply, blend multiply, divide by 255 and
// write-back into the result register, and waits in that last step while a
// finished result is not popped. Store entries read before they were ever
// cleared return arbitrary values. Configuration writes are always ready and
// are to be made while idle.
module fragment_depth_test_blend #(
    parameter int ADDRESS_BITS = fdtb_pkg::ADDRESS_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fdtb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fdtb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 kind,
    input  logic [fdtb_pkg::ADDR_IN_W-1:0]       address,
    input  logic [fdtb_pkg::DEPTH_W-1:0]         depth,
    input  logic [fdtb_pkg::COLOR_W-1:0]         color,
    input  logic signed [fdtb_pkg::SHADE_W-1:0]  shade,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 written,
    output logic [fdtb_pkg::COLOR_W-1:0]         color_out,
    output logic [fdtb_pkg::DEPTH_W-1:0]         depth_out
);

    localparam int WORK_W = $bits(fdtb_pkg::work_t);
    localparam int Q_W    = ADDRESS_BITS + WORK_W;

    logic                    q_wr_en;
    logic                    q_full;
    logic                    q_rd_en;
    logic                    q_empty;
    logic [ADDRESS_BITS-1:0] in_addr;
    fdtb_pkg::work_t         in_work;
    logic [Q_W-1:0]          q_head;
    logic [ADDRESS_BITS-1:0] head_addr;
    fdtb_pkg::work_t         head_work;

    assign head_addr = q_head[Q_W-1:WORK_W];
    assign head_work = q_head[WORK_W-1:0];

    fdtb_front #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .address   (address),
        .depth     (depth),
        .color     (color),
        .shade     (shade),
        .q_wr_en   (q_wr_en),
        .q_addr    (in_addr),
        .q_work    (in_work),
        .q_full    (q_full)
    );

    fdtb_fifo #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data ({in_addr, in_work}),
        .full    (q_full),
        .rd_en   (q_rd_en),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    fdtb_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_addr    (head_addr),
        .q_work    (head_work),
        .q_rd_en   (q_rd_en),
        .pop       (pop),
        .empty     (empty),
        .written   (written),
        .color_out (color_out),
        .depth_out (depth_out)
    );

endmodule

// File: test/tb.sv
// Self-checking testbench for fragment_depth_test_blend: directed and random items
// through the push/pop queue ports, checked against an in-bench store and blend predictor.
// Depends on fdtb_pkg and the RTL under rtl; reads no files.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fdtb_pkg::*;

    // Mode three has no meaning; the block treats it as no blend
    localparam logic [1:0] BLEND_UNDEFINED = 2'd3;

    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int POOL_SIZE       = 8;
    localparam int SETTLE_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct {
        logic        written;
        logic [31:0] color;
        logic [31:0] depth;
    } pixel_result_t;

    // DUT signals
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                 push      = 1'b0;
    logic                 full;
    logic                 kind      = KIND_CLEAR;
    logic [15:0]          address   = '0;
    logic [31:0]          depth     = '0;
    logic [31:0]          color     = '0;
    logic signed [15:0]   shade     = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    logic                 written;
    logic [31:0]          color_out;
    logic [31:0]          depth_out;

    // Predictor state: register copies, stores, and which entries hold data
    logic [1:0]  cfg_blend  = BLEND_MODE_RST;
    logic        cfg_smooth = SMOOTH_SHADE_RST;
    logic [8:0]  cfg_alpha  = ALPHA_FACTOR_RST;
    bit [31:0]   depth_mem [0:65535];
    bit [31:0]   color_mem [0:65535];
    bit          ever_cleared [0:65535];

    pixel_result_t pending_results[$];
    int            error_count   = 0;
    int            quiet_cycles  = 0;
    bit            back_to_back  = 1'b0;

    fragment_depth_test_blend u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .address   (address),
        .depth     (depth),
        .color     (color),
        .shade     (shade),
        .empty     (empty),
        .pop       (pop),
        .written   (written),
        .color_out (color_out),
        .depth_out (depth_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Per-item wait on either side; zero during back-to-back stretches
    function automatic int idle_cycles();
        if (back_to_back)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    // Shade, then blend, a texel against the destination color
    function automatic logic [31:0] blend_pixel(input logic [31:0] texel,
                                                input logic [31:0] dest,
                                                input logic signed [15:0] shade_in);
        logic [1:0]  mode;
        logic [31:0] res;
        int          s;
        int          a;
        int          c;
        int          d;
        int          sh;
        mode = (cfg_blend == BLEND_ADD || cfg_blend == BLEND_ALPHA) ? cfg_blend : BLEND_NONE;
        if (mode == BLEND_NONE && !cfg_smooth)
            return texel;
        s = int'(shade_in);
        if (s < 0)
            s = 0;
        if (s > int'(SHADE_ONE))
            s = int'(SHADE_ONE);
        a = (int'(texel[31:24]) * int'(cfg_alpha)) >> 8;
        if (a > int'(CHAN_MAX))
            a = int'(CHAN_MAX);
        res = {CHAN_MAX, 24'h0};
        for (int k = 0; k < 3; k++)
        begin
            sh = 16 - 8 * k;
            c  = int'(texel[sh +: 8]);
            d  = int'(dest[sh +: 8]);
            if (cfg_smooth)
                c = (c * s) >> 14;
            if (mode == BLEND_ADD)
                c = (c + d > 255) ? 255 : c + d;
            else if (mode == BLEND_ALPHA)
                c = (a * c + (255 - a) * d) / 255;
            res[sh +: 8] = c[7:0];
        end
        return res;
    endfunction

    // Update the stores for one accepted item and queue what the block must return
    task automatic apply_to_stores(input logic item_kind, input logic [15:0] item_addr,
                                   input logic [31:0] item_depth, input logic [31:0] item_color,
                                   input logic signed [15:0] item_shade);
        pixel_result_t res;
        res.written = 1'b0;
        if (item_kind == KIND_CLEAR)
        begin
            depth_mem[item_addr]    = item_depth;
            color_mem[item_addr]    = item_color;
            ever_cleared[item_addr] = 1'b1;
            res.written = 1'b1;
        end
        else if (item_depth >= depth_mem[item_addr])
        begin
            depth_mem[item_addr] = item_depth;
            color_mem[item_addr] = blend_pixel(item_color, color_mem[item_addr], item_shade);
            res.written = 1'b1;
        end
        res.color = color_mem[item_addr];
        res.depth = depth_mem[item_addr];
        pending_results.push_back(res);
    endtask

    // One input transfer; push stays high when the next item follows at once
    task automatic send_item(input logic item_kind, input logic [15:0] item_addr,
                             input logic [31:0] item_depth, input logic [31:0] item_color,
                             input logic signed [15:0] item_shade);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        kind    <= item_kind;
        address <= item_addr;
        depth   <= item_depth;
        color   <= item_color;
        shade   <= item_shade;
        do @(posedge clk); while (full !== 1'b0);
        apply_to_stores(item_kind, item_addr, item_depth, item_color, item_shade);
    endtask

    // Stop pushing, wait for every expected result, then let the pipeline settle
    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; cfg_valid is left high for a following write
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_BLEND_MODE:   cfg_blend  = data[1:0];
            CFG_SMOOTH_SHADE: cfg_smooth = data[0];
            CFG_ALPHA_FACTOR: cfg_alpha  = data[8:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] mode, input logic smooth,
                              input logic [8:0] factor);
        drain_results();
        write_register(CFG_BLEND_MODE, {7'd0, mode});
        write_register(CFG_SMOOTH_SHADE, {8'd0, smooth});
        write_register(CFG_ALPHA_FACTOR, factor);
        cfg_valid <= 1'b0;
    endtask

    // Clears at the address extremes with extreme depths and colors, plus one in the middle
    task automatic test_clear_extremes();
        send_item(KIND_CLEAR, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'sd0);
        send_item(KIND_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd1);
        send_item(KIND_CLEAR, 16'h5A5A, 32'd1000, 32'h8040_2010, 16'sd16384);
    endtask

    // Equal depth passes, lower depth is rejected, higher depth passes
    task automatic test_depth_compare();
        send_item(KIND_FRAGMENT, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 16'sd16384);
        send_item(KIND_FRAGMENT, 16'hFFFF, 32'hFFFF_FFFE, 32'h1234_5678, 16'sd16384);
        send_item(KIND_FRAGMENT, 16'hFFFF, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 16'sd8192);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd999, 32'h0F0F_0F0F, 16'sd16384);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd1001, 32'hF0F0_F0F0, 16'sd16384);
    endtask

    // Shade below zero, at the ends and above one, with smoothing on
    task automatic test_shade_clamp();
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd2000, 32'h12FF_8040, -16'sd32768);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd2001, 32'h12FF_8040, -16'sd1);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd2002, 32'h12FF_8040, 16'sd0);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd2003, 32'h12FF_8040, 16'sd8192);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd2004, 32'h12FF_8040, 16'sd16384);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd2005, 32'h12FF_8040, 16'sd16385);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd2006, 32'h12FF_8040, 16'sd32767);
    endtask

    // Each blend mode, the undefined mode, and alpha factor extremes
    task automatic test_blend_modes();
        set_config(BLEND_NONE, 1'b0, 9'd256);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd3000, 32'h3366_99CC, 16'sd0);
        set_config(BLEND_ADD, 1'b0, 9'd256);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd3001, 32'h40C0_8020, 16'sd0);
        set_config(BLEND_ALPHA, 1'b1, 9'd0);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd3002, 32'hFF20_4060, 16'sd12000);
        set_config(BLEND_ALPHA, 1'b0, 9'd511);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd3003, 32'h8011_2233, 16'sd0);
        set_config(BLEND_ALPHA, 1'b0, 9'd256);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd3004, 32'h7FFF_0080, 16'sd0);
        set_config(BLEND_UNDEFINED, 1'b0, 9'd256);
        send_item(KIND_FRAGMENT, 16'h5A5A, 32'd3005, 32'h0102_0304, 16'sd0);
    endtask

    // Phases of clear-then-fragment sequences over a small address pool, plus noise
    task automatic test_random_traffic();
        logic [15:0]        pool [POOL_SIZE];
        logic [15:0]        addr;
        logic [31:0]        frag_depth;
        logic signed [15:0] frag_shade;
        logic [8:0]         factor;
        longint             stored;
        int                 r;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase % 3)
                0:       factor = 9'd256;
                1:       factor = 9'($urandom_range(0, 511));
                default: factor = (phase % 2 == 0) ? 9'd0 : 9'd511;
            endcase
            set_config(2'(phase % 4), 1'((phase / 4) % 2), factor);
            back_to_back = (phase % 4 == 3);
            for (int p = 0; p < POOL_SIZE; p++)
                pool[p] = 16'($urandom_range(0, 65535));
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                r    = $urandom_range(0, 99);
                addr = pool[$urandom_range(0, POOL_SIZE - 1)];
                if (r < 8)
                    // stray clear anywhere in the store
                    send_item(KIND_CLEAR, 16'($urandom_range(0, 65535)), $urandom(),
                              $urandom(), 16'($urandom()));
                else if (r < 22 || !ever_cleared[addr])
                    send_item(KIND_CLEAR, addr,
                              $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 100000),
                              $urandom(), 16'($urandom()));
                else
                begin
                    stored = longint'(depth_mem[addr]);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5:
                        begin
                            stored = stored + $urandom_range(0, 1000);
                            frag_depth = (stored > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                  : 32'(stored);
                        end
                        6:       frag_depth = 32'(stored);
                        7, 8:
                        begin
                            stored = stored - $urandom_range(1, 1000);
                            frag_depth = (stored < 0) ? 32'd0 : 32'(stored);
                        end
                        default: frag_depth = $urandom();
                    endcase
                    case ($urandom_range(0, 3))
                        0, 1:    frag_shade = 16'($urandom_range(0, 16384));
                        2:       frag_shade = 16'($urandom());
                        default:
                        case ($urandom_range(0, 5))
                            0:       frag_shade = -16'sd32768;
                            1:       frag_shade = -16'sd1;
                            2:       frag_shade = 16'sd0;
                            3:       frag_shade = 16'sd16384;
                            4:       frag_shade = 16'sd16385;
                            default: frag_shade = 16'sd32767;
                        endcase
                    endcase
                    send_item(KIND_FRAGMENT, addr, frag_depth, $urandom(), frag_shade);
                end
            end
        end
        back_to_back = 1'b0;
    endtask

    // Main sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_clear_extremes();
        test_depth_compare();
        test_shade_clamp();
        test_blend_modes();
        test_random_traffic();
        drain_results();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: random pop gaps, compare each transfer with the oldest expectation
    initial
    begin : result_checker
        int            gap;
        pixel_result_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = idle_cycles();
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty !== 1'b0);
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: written %0d color_out %08h depth_out %08h",
                       written, color_out, depth_out);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (written !== want.written)
                begin
                    $error("written: expected %0d, got %0d", want.written, written);
                    error_count++;
                end
                if (color_out !== want.color)
                begin
                    $error("color_out: expected %08h, got %08h", want.color, color_out);
                    error_count++;
                end
                if (depth_out !== want.depth)
                begin
                    $error("depth_out: expected %08h, got %08h", want.depth, depth_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// File: fragment_depth_test_blend.f
rtl/fdtb_pkg.sv
rtl/fdtb_fifo.sv
rtl/fdtb_front.sv
rtl/fdtb_back.sv
rtl/fragment_depth_test_blend.sv
test/tb.sv
